@@ rtl/rsp_pkg.sv @@
// Shared types, constants and helpers for the ramped-setpoint PID controller.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps

package rsp_pkg;

  // Default number format
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed port widths
  localparam int POS_W      = 32;
  localparam int DRIVE_W    = 24;
  localparam int GAIN_W     = 24;
  localparam int RAMP_W     = 31;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd4;

  // Register reset values
  localparam logic signed [POS_W-1:0]  TARGET_RST = 32'sd0;
  localparam logic [RAMP_W-1:0]        RAMP_RST   = 31'd65536;
  localparam logic signed [GAIN_W-1:0] KP_RST     = 24'sd108134;
  localparam logic signed [GAIN_W-1:0] KI_RST     = 24'sd26214;
  localparam logic signed [GAIN_W-1:0] KD_RST     = 24'sd0;

  // Scaling constants (whole numbers, scaled by FRAC_BITS where needed)
  localparam int DERIV_SCALE = 50;
  localparam int INT_LIMIT   = 50;
  localparam int DRIVE_LIMIT = 100;

  // Multiplier: second operand width and digit size per step
  localparam int MB_W      = 24;
  localparam int DIGIT_W   = 8;
  localparam int MUL_RES_W = 62;

  // Wide working format for sums and saturation
  localparam int WIDE_W = 80;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // Largest product magnitude, 2^61 - 1
  localparam logic [WIDE_W-1:0] PROD_MAX = (80'd1 << 61) - 80'd1;

  // Multiplier control from the sequencer
  typedef struct packed {
    logic start;
    logic scale;   // shift the product right by FRAC_BITS
  } mul_ctl_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SLOPE_GO,
    S_SLOPE_WAIT,
    S_SNAP,
    S_ERR,
    S_INT_GO,
    S_INT_WAIT,
    S_INT_CLAMP,
    S_DER_GO,
    S_DER_WAIT,
    S_P_GO,
    S_P_WAIT,
    S_I_GO,
    S_I_WAIT,
    S_D_GO,
    S_D_WAIT,
    S_DONE
  } state_t;

  // Saturate x to a signed range of w bits
  function automatic wide_t sat_w(input wide_t x, input int unsigned w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (x > hi) begin
      return hi;
    end else if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

  // Clamp x to [-lim, lim]
  function automatic wide_t clamp_w(input wide_t x, input wide_t lim);
    if (x > lim) begin
      return lim;
    end else if (x < -lim) begin
      return -lim;
    end
    return x;
  endfunction

endpackage

@@ rtl/rsp_mul.sv @@
// Iterative signed fixed-point multiplier, one 8-bit digit of b per cycle.
// Depends on rsp_pkg (digit size, result width, saturation limit).
`timescale 1ns / 1ps

module rsp_mul #(
  parameter int A_W       = rsp_pkg::DATA_WIDTH_DEF + 1,
  parameter int FRAC_BITS = rsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rsp_pkg::mul_ctl_t                    ctl,
  input  logic signed [A_W-1:0]                a,
  input  logic signed [rsp_pkg::MB_W-1:0]      b,
  output logic                                 done,
  output logic signed [rsp_pkg::MUL_RES_W-1:0] res
);

  localparam int MB_W   = rsp_pkg::MB_W;
  localparam int DIG_W  = rsp_pkg::DIGIT_W;
  localparam int STEPS  = MB_W / DIG_W;
  localparam int CNT_W  = $clog2(STEPS + 1);
  localparam int PROD_W = A_W + MB_W;
  localparam int WIDE_W = rsp_pkg::WIDE_W;
  localparam int RES_W  = rsp_pkg::MUL_RES_W;

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic [A_W-1:0]         a_mag;
  logic [MB_W-1:0]        b_sh;
  logic                   neg;
  logic                   scale;
  logic [PROD_W-1:0]      acc;

  logic [A_W-1:0]         a_abs;
  logic [MB_W-1:0]        b_abs;
  logic [A_W+DIG_W-1:0]   pp;
  logic [PROD_W-1:0]      acc_next;
  logic [WIDE_W-1:0]      prod_sh;
  logic [WIDE_W-1:0]      prod_sat;
  logic [RES_W-1:0]       res_mag;

  // Operand magnitudes
  assign a_abs = a[A_W-1] ? (~a + A_W'(1)) : a;
  assign b_abs = b[MB_W-1] ? (~b + MB_W'(1)) : b;

  // One digit step: shift the sum up and add the next partial product
  assign pp       = a_mag * b_sh[MB_W-1 -: DIG_W];
  assign acc_next = (acc << DIG_W) + PROD_W'(pp);

  // Final scaling and saturation
  assign prod_sh  = scale ? (WIDE_W'(acc) >> FRAC_BITS) : WIDE_W'(acc);
  assign prod_sat = (prod_sh > rsp_pkg::PROD_MAX) ? rsp_pkg::PROD_MAX : prod_sh;
  assign res_mag  = prod_sat[RES_W-1:0];

  // Control: start, step through digits, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_mag <= a_abs;
      b_sh  <= b_abs;
      neg   <= a[A_W-1] ^ b[MB_W-1];
      scale <= ctl.scale;
      acc   <= '0;
    end else if (busy) begin
      if (cnt == CNT_W'(STEPS)) begin
        res <= neg ? -$signed(res_mag) : $signed(res_mag);
      end else begin
        acc  <= acc_next;
        b_sh <= b_sh << DIG_W;
      end
    end
  end

endmodule

@@ rtl/rsp_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rsp_pkg only for its parameter defaults; the top level hands down the widths.
`timescale 1ns / 1ps

module rsp_div #(
  parameter int NUM_W = rsp_pkg::DATA_WIDTH_DEF + rsp_pkg::FRAC_BITS_DEF,
  parameter int DEN_W = rsp_pkg::RAMP_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Bring down the next numerator bit and try the subtract
  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= den;
      quo <= num;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, dsr}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

@@ rtl/ramped_setpoint_pid.sv @@
// Top level of the ramped-setpoint PID controller: sequencer, state and registers.
// Depends on rsp_pkg, rsp_mul and rsp_div.
`timescale 1ns / 1ps

// One measured position sample in gives one drive command out. For each sample
// the ramp slope comes from a one-bit-per-cycle divider, and six products go
// one after another through a single multiplier that handles eight bits of its
// second operand per cycle. With ramp_time at zero the divider and the ramp
// product are skipped. in_stall is high while a sample is being worked on; the
// next sample is taken while the previous drive still waits in the output
// register. Write configuration only while the block is idle.

module ramped_setpoint_pid #(
  parameter int DATA_WIDTH = rsp_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample in
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rsp_pkg::POS_W-1:0]      measured_position,
  // drive out
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [rsp_pkg::DRIVE_W-1:0]    drive,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rsp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int DW     = DATA_WIDTH;
  localparam int A_W    = DW + 1;
  localparam int NUM_W  = DW + FRAC_BITS;
  localparam int MB_W   = rsp_pkg::MB_W;
  localparam int RES_W  = rsp_pkg::MUL_RES_W;
  localparam int DT     = ((1 << FRAC_BITS) * 2 + 50) / 100;

  localparam rsp_pkg::wide_t INT_LIM   = rsp_pkg::wide_t'(rsp_pkg::INT_LIMIT) <<< FRAC_BITS;
  localparam rsp_pkg::wide_t DRIVE_LIM =
    rsp_pkg::wide_t'(rsp_pkg::DRIVE_LIMIT) <<< FRAC_BITS;

  // Configuration registers
  logic signed [rsp_pkg::POS_W-1:0]  target_distance;
  logic [rsp_pkg::RAMP_W-1:0]        ramp_time;
  logic signed [rsp_pkg::GAIN_W-1:0] kp;
  logic signed [rsp_pkg::GAIN_W-1:0] ki;
  logic signed [rsp_pkg::GAIN_W-1:0] kd;

  // Controller state and per-sample working registers
  rsp_pkg::state_t      state;
  rsp_pkg::state_t      state_next;
  logic signed [DW-1:0] sp;
  logic signed [DW-1:0] integ;
  logic signed [DW-1:0] prev;
  logic signed [DW-1:0] target;
  logic signed [DW-1:0] meas;
  logic signed [DW-1:0] slope;
  logic signed [DW-1:0] err;
  logic signed [DW-1:0] deriv;
  logic signed [A_W-1:0] diff;
  rsp_pkg::wide_t       acc;

  // Shared units
  rsp_pkg::mul_ctl_t        mul_ctl;
  logic signed [A_W-1:0]    mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic                     mul_done;
  logic signed [RES_W-1:0]  mul_res;
  logic                     div_start;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;
  logic [DW-1:0]            tgt_mag;
  logic [NUM_W-1:0]         div_num;

  // Combinational candidates
  rsp_pkg::wide_t tgt_w;
  rsp_pkg::wide_t meas_w;
  rsp_pkg::wide_t slope_raw;
  rsp_pkg::wide_t slope_w;
  rsp_pkg::wide_t mul_w;
  rsp_pkg::wide_t sp_sum_w;
  rsp_pkg::wide_t abs_sp;
  rsp_pkg::wide_t abs_tgt;
  rsp_pkg::wide_t err_w;
  rsp_pkg::wide_t int_sum_w;
  rsp_pkg::wide_t int_clamp_w;
  rsp_pkg::wide_t drive_w;
  logic           in_xfer;
  logic           out_free;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      target_distance <= rsp_pkg::TARGET_RST;
      ramp_time       <= rsp_pkg::RAMP_RST;
      kp              <= rsp_pkg::KP_RST;
      ki              <= rsp_pkg::KI_RST;
      kd              <= rsp_pkg::KD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rsp_pkg::REG_TARGET: target_distance <= cfg_data;
        rsp_pkg::REG_RAMP:   ramp_time       <= cfg_data[rsp_pkg::RAMP_W-1:0];
        rsp_pkg::REG_KP:     kp              <= cfg_data[rsp_pkg::GAIN_W-1:0];
        rsp_pkg::REG_KI:     ki              <= cfg_data[rsp_pkg::GAIN_W-1:0];
        rsp_pkg::REG_KD:     kd              <= cfg_data[rsp_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturated candidates for each update step
  always_comb begin
    tgt_w     = rsp_pkg::sat_w(rsp_pkg::wide_t'(target_distance), DW);
    meas_w    = rsp_pkg::sat_w(rsp_pkg::wide_t'(measured_position), DW);
    slope_raw = rsp_pkg::wide_t'({{(rsp_pkg::WIDE_W - NUM_W){1'b0}}, div_quo});
    slope_w   = rsp_pkg::sat_w(target[DW-1] ? -slope_raw : slope_raw, DW);
    mul_w     = rsp_pkg::sat_w(rsp_pkg::wide_t'(mul_res), DW);
    sp_sum_w  = rsp_pkg::sat_w(rsp_pkg::wide_t'(sp) + mul_w, DW);
    abs_sp    = sp[DW-1] ? -rsp_pkg::wide_t'(sp) : rsp_pkg::wide_t'(sp);
    abs_tgt   = target[DW-1] ? -rsp_pkg::wide_t'(target) : rsp_pkg::wide_t'(target);
    err_w     = rsp_pkg::sat_w(rsp_pkg::wide_t'(sp) - rsp_pkg::wide_t'(meas), DW);
    int_sum_w = rsp_pkg::sat_w(rsp_pkg::wide_t'(integ) + mul_w, DW);
    int_clamp_w = rsp_pkg::sat_w(rsp_pkg::clamp_w(rsp_pkg::wide_t'(integ), INT_LIM), DW);
    drive_w   = rsp_pkg::clamp_w(acc, DRIVE_LIM);
  end

  // Divider operands: |target| scaled up by FRAC_BITS over the ramp time
  assign tgt_mag = target[DW-1] ? (~target + DW'(1)) : target;
  assign div_num = {tgt_mag, {FRAC_BITS{1'b0}}};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rsp_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_next = (ramp_time == '0) ? rsp_pkg::S_ERR : rsp_pkg::S_DIV_GO;
        end
      end
      rsp_pkg::S_DIV_GO:     state_next = rsp_pkg::S_DIV_WAIT;
      rsp_pkg::S_DIV_WAIT:   if (div_done) state_next = rsp_pkg::S_SLOPE_GO;
      rsp_pkg::S_SLOPE_GO:   state_next = rsp_pkg::S_SLOPE_WAIT;
      rsp_pkg::S_SLOPE_WAIT: if (mul_done) state_next = rsp_pkg::S_SNAP;
      rsp_pkg::S_SNAP:       state_next = rsp_pkg::S_ERR;
      rsp_pkg::S_ERR:        state_next = rsp_pkg::S_INT_GO;
      rsp_pkg::S_INT_GO:     state_next = rsp_pkg::S_INT_WAIT;
      rsp_pkg::S_INT_WAIT:   if (mul_done) state_next = rsp_pkg::S_INT_CLAMP;
      rsp_pkg::S_INT_CLAMP:  state_next = rsp_pkg::S_DER_GO;
      rsp_pkg::S_DER_GO:     state_next = rsp_pkg::S_DER_WAIT;
      rsp_pkg::S_DER_WAIT:   if (mul_done) state_next = rsp_pkg::S_P_GO;
      rsp_pkg::S_P_GO:       state_next = rsp_pkg::S_P_WAIT;
      rsp_pkg::S_P_WAIT:     if (mul_done) state_next = rsp_pkg::S_I_GO;
      rsp_pkg::S_I_GO:       state_next = rsp_pkg::S_I_WAIT;
      rsp_pkg::S_I_WAIT:     if (mul_done) state_next = rsp_pkg::S_D_GO;
      rsp_pkg::S_D_GO:       state_next = rsp_pkg::S_D_WAIT;
      rsp_pkg::S_D_WAIT:     if (mul_done) state_next = rsp_pkg::S_DONE;
      rsp_pkg::S_DONE:       if (out_free) state_next = rsp_pkg::S_IDLE;
      default:               state_next = rsp_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and shared-unit operands
  always_comb begin
    in_stall      = (state != rsp_pkg::S_IDLE);
    div_start     = 1'b0;
    mul_ctl.start = 1'b0;
    mul_ctl.scale = 1'b1;
    mul_a         = A_W'(err);
    mul_b         = MB_W'(DT);
    unique case (state)
      rsp_pkg::S_DIV_GO: div_start = 1'b1;
      rsp_pkg::S_SLOPE_GO: begin
        mul_ctl.start = 1'b1;
        mul_a         = A_W'(slope);
      end
      rsp_pkg::S_INT_GO: begin
        mul_ctl.start = 1'b1;
      end
      rsp_pkg::S_DER_GO: begin
        mul_ctl.start = 1'b1;
        mul_ctl.scale = 1'b0;
        mul_a         = diff;
        mul_b         = MB_W'(rsp_pkg::DERIV_SCALE);
      end
      rsp_pkg::S_P_GO: begin
        mul_ctl.start = 1'b1;
        mul_b         = kp;
      end
      rsp_pkg::S_I_GO: begin
        mul_ctl.start = 1'b1;
        mul_a         = A_W'(integ);
        mul_b         = ki;
      end
      rsp_pkg::S_D_GO: begin
        mul_ctl.start = 1'b1;
        mul_a         = A_W'(deriv);
        mul_b         = kd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Controller state that persists across samples
  always_ff @(posedge clk) begin
    if (rst) begin
      sp    <= '0;
      integ <= '0;
      prev  <= '0;
    end else begin
      unique case (state)
        rsp_pkg::S_IDLE: begin
          if (in_xfer && ramp_time == '0) begin
            sp <= tgt_w[DW-1:0];
          end
        end
        rsp_pkg::S_SLOPE_WAIT: if (mul_done) sp <= sp_sum_w[DW-1:0];
        rsp_pkg::S_SNAP:       if (abs_sp > abs_tgt) sp <= target;
        rsp_pkg::S_INT_GO:     prev <= err;
        rsp_pkg::S_INT_WAIT:   if (mul_done) integ <= int_sum_w[DW-1:0];
        rsp_pkg::S_INT_CLAMP:  integ <= int_clamp_w[DW-1:0];
        default: ;
      endcase
    end
  end

  // Per-sample working registers
  always_ff @(posedge clk) begin
    case (state) inside
      rsp_pkg::S_IDLE: begin
        if (in_xfer) begin
          target <= tgt_w[DW-1:0];
          meas   <= meas_w[DW-1:0];
        end
      end
      rsp_pkg::S_DIV_WAIT: if (div_done) slope <= slope_w[DW-1:0];
      rsp_pkg::S_ERR:      err  <= err_w[DW-1:0];
      rsp_pkg::S_INT_GO:   diff <= A_W'(err) - A_W'(prev);
      rsp_pkg::S_DER_WAIT: if (mul_done) deriv <= mul_w[DW-1:0];
      rsp_pkg::S_P_WAIT:   if (mul_done) acc <= rsp_pkg::wide_t'(mul_res);
      rsp_pkg::S_I_WAIT,
      rsp_pkg::S_D_WAIT:   if (mul_done) acc <= acc + rsp_pkg::wide_t'(mul_res);
      default: ;
    endcase
  end

  // Output register: load the drive once the previous one has transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rsp_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rsp_pkg::S_DONE && out_free) begin
      drive <= drive_w[rsp_pkg::DRIVE_W-1:0];
    end
  end

  rsp_mul #(
    .A_W       (A_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  rsp_div #(
    .NUM_W (NUM_W),
    .DEN_W (rsp_pkg::RAMP_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (ramp_time),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

@@ rtl/rsp_check.sv @@
// Port-level checker for the ramped-setpoint PID controller, bound to the top.
// Depends on rsp_pkg for port widths and the drive limit.
`timescale 1ns / 1ps

module rsp_check #(
  parameter int FRAC_BITS = rsp_pkg::FRAC_BITS_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [rsp_pkg::DRIVE_W-1:0] drive
);

  localparam int LIM      = rsp_pkg::DRIVE_LIMIT << FRAC_BITS;
  localparam bit RANGE_OK = (FRAC_BITS <= 16);

  // Reset leaves the block idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // A sample transfer keeps the block busy on the next cycle
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took no time on a sample");

  // A new drive appears only at the end of a busy period
  a_out_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("drive appeared without work");

  // A stalled drive holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(drive))
    else $error("stalled drive changed");

  // Drive stays within plus or minus 100
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !RANGE_OK || (drive <= LIM && drive >= -LIM))
    else $error("drive out of range");

endmodule

bind ramped_setpoint_pid rsp_check #(
  .FRAC_BITS (FRAC_BITS)
) u_rsp_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive     (drive)
);

@@ tb/sv/tb.sv @@
// Self-checking bench for ramped_setpoint_pid: a directed table, then random tuning phases.
// Depends on rsp_pkg and the RTL in rtl/; expected drives come from a local fixed-point model.
`timescale 1ns / 1ps

module tb;
  import rsp_pkg::*;

  localparam int     FB          = FRAC_BITS_DEF;
  localparam longint ONE_Q       = longint'(1) << FB;
  localparam longint DT_Q        = (ONE_Q * 2 + 50) / 100;
  localparam longint DMAX        = (longint'(1) << (DATA_WIDTH_DEF - 1)) - 1;
  localparam longint DMIN        = -DMAX - 1;
  localparam longint PROD_LIM    = (longint'(1) << 61) - 1;
  localparam logic signed [DRIVE_W-1:0] DRIVE_FULL = DRIVE_W'(DRIVE_LIMIT * ONE_Q);

  // Indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam int     RANDOM_ITEMS    = 1030;
  localparam int     QUIET_ITEMS     = 100;
  localparam int     HOLD_OFF_CYCLES = 600;
  localparam int     DRAIN_CYCLES    = 200;
  localparam longint CYCLE_LIMIT     = 1000000;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [POS_W-1:0]    measured_position;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [DRIVE_W-1:0]  drive;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  ramped_setpoint_pid u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .measured_position (measured_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .drive             (drive),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Controller copy: registers and loop state as the block should hold them
  logic signed [POS_W-1:0]    m_target;
  logic [RAMP_W-1:0]          m_ramp;
  logic signed [GAIN_W-1:0]   m_kp;
  logic signed [GAIN_W-1:0]   m_ki;
  logic signed [GAIN_W-1:0]   m_kd;
  longint                     m_setpoint;
  longint                     m_integral;
  longint                     m_prev_err;

  logic signed [DRIVE_W-1:0]  pending_drives [$];
  int                         mismatches = 0;
  longint                     cycle_count = 0;
  bit                         quiet = 1'b0;
  bit                         hold_off_req = 1'b0;

  // Directed table: config writes and samples, some with a drive known by inspection
  typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_SAMPLE_KNOWN} row_kind_t;
  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_DATA_W-1:0]     value;
    logic signed [DRIVE_W-1:0] want;
  } dir_row_t;

  localparam int DIR_ROWS = 40;
  dir_row_t directed_rows [DIR_ROWS] = '{
    // reset defaults: zero in gives zero out, extremes pin the drive
    '{ROW_SAMPLE_KNOWN, '0,            32'h0000_0000, '0},
    '{ROW_SAMPLE_KNOWN, '0,            32'h7FFF_FFFF, -DRIVE_FULL},
    '{ROW_SAMPLE_KNOWN, '0,            32'h8000_0000, DRIVE_FULL},
    '{ROW_SAMPLE,       '0,            32'h0001_2345, '0},
    // writes past the register list
    '{ROW_CFG,          REG_UNUSED_LO, 32'hFFFF_FFFF, '0},
    '{ROW_CFG,          REG_UNUSED_HI, 32'hFFFF_FFFF, '0},
    '{ROW_SAMPLE,       '0,            32'h0000_1000, '0},
    // step setpoint straight to 100.0
    '{ROW_CFG,          REG_RAMP,      32'h0000_0000, '0},
    '{ROW_CFG,          REG_TARGET,    32'h0064_0000, '0},
    '{ROW_SAMPLE,       '0,            32'h0000_0000, '0},
    '{ROW_SAMPLE,       '0,            32'h0064_0000, '0},
    '{ROW_SAMPLE,       '0,            32'h0063_0000, '0},
    // most negative target with the shortest ramp: slope saturates
    '{ROW_CFG,          REG_TARGET,    32'h8000_0000, '0},
    '{ROW_CFG,          REG_RAMP,      32'h0000_0001, '0},
    '{ROW_SAMPLE,       '0,            32'h0000_0000, '0},
    '{ROW_SAMPLE,       '0,            32'h8000_0000, '0},
    // largest target with the longest ramp
    '{ROW_CFG,          REG_TARGET,    32'h7FFF_FFFF, '0},
    '{ROW_CFG,          REG_RAMP,      32'hFFFF_FFFF, '0},
    '{ROW_SAMPLE,       '0,            32'h0000_0000, '0},
    '{ROW_SAMPLE,       '0,            32'h7FFF_FFFF, '0},
    // park setpoint at +10, then flip target to -2 so it snaps
    '{ROW_CFG,          REG_RAMP,      32'h0000_0000, '0},
    '{ROW_CFG,          REG_TARGET,    32'h000A_0000, '0},
    '{ROW_SAMPLE,       '0,            32'h0005_0000, '0},
    '{ROW_CFG,          REG_TARGET,    32'hFFFE_0000, '0},
    '{ROW_CFG,          REG_RAMP,      32'h0001_0000, '0},
    '{ROW_SAMPLE,       '0,            32'h0000_0000, '0},
    '{ROW_SAMPLE,       '0,            32'hFFFF_0000, '0},
    // gain extremes
    '{ROW_CFG,          REG_KP,        32'h007F_FFFF, '0},
    '{ROW_CFG,          REG_KI,        32'hFF80_0000, '0},
    '{ROW_CFG,          REG_KD,        32'h007F_FFFF, '0},
    '{ROW_SAMPLE,       '0,            32'h0000_1234, '0},
    '{ROW_SAMPLE,       '0,            32'hFFF0_0000, '0},
    '{ROW_CFG,          REG_KD,        32'h0080_0000, '0},
    '{ROW_CFG,          REG_KP,        32'h0000_0000, '0},
    '{ROW_SAMPLE,       '0,            32'h0010_0000, '0},
    '{ROW_SAMPLE,       '0,            32'h7FFF_FFFF, '0},
    // all gains zero: drive must be zero
    '{ROW_CFG,          REG_KI,        32'h0000_0000, '0},
    '{ROW_CFG,          REG_KD,        32'h0000_0000, '0},
    '{ROW_SAMPLE_KNOWN, '0,            32'h5A5A_5A5A, '0},
    '{ROW_SAMPLE_KNOWN, '0,            32'hA5A5_A5A5, '0}
  };

  function automatic longint sat_data(input longint x);
    return (x > DMAX) ? DMAX : ((x < DMIN) ? DMIN : x);
  endfunction

  function automatic longint clamp_mag(input longint x, input longint lim);
    return (x > lim) ? lim : ((x < -lim) ? -lim : x);
  endfunction

  // Fixed-point product: exact, truncated toward zero, limited to +-(2^61 - 1)
  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] ua;
    logic [127:0] ub;
    logic [127:0] r;
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    r = (ua * ub) >> FB;
    if (r > 128'(PROD_LIM)) begin
      r = 128'(PROD_LIM);
    end
    return ((a < 0) != (b < 0)) ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  // Advance the controller copy by one sample and return the drive it commands
  function automatic logic signed [DRIVE_W-1:0] next_drive(input logic signed [POS_W-1:0] pos);
    longint tgt;
    longint slope;
    longint err;
    longint deriv;
    longint total;
    tgt = longint'(m_target);
    if (m_ramp == '0) begin
      m_setpoint = tgt;
    end else begin
      slope = sat_data((tgt * ONE_Q) / longint'(m_ramp));
      m_setpoint = sat_data(m_setpoint + sat_data(fx_mul(slope, DT_Q)));
      // snap once the setpoint passes the target's magnitude
      if (((m_setpoint < 0) ? -m_setpoint : m_setpoint) > ((tgt < 0) ? -tgt : tgt)) begin
        m_setpoint = tgt;
      end
    end
    err = sat_data(m_setpoint - longint'(pos));
    m_integral = sat_data(m_integral + sat_data(fx_mul(err, DT_Q)));
    m_integral = clamp_mag(m_integral, INT_LIMIT * ONE_Q);
    deriv = sat_data((err - m_prev_err) * DERIV_SCALE);
    total = fx_mul(longint'(m_kp), err) + fx_mul(longint'(m_ki), m_integral)
          + fx_mul(longint'(m_kd), deriv);
    m_prev_err = err;
    total = clamp_mag(total, DRIVE_LIMIT * ONE_Q);
    return total[DRIVE_W-1:0];
  endfunction

  // Gain write: extremes, zero, full noise or a moderate value; junk above bit 23
  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 32'h007F_FFFF;
      1:       return 32'h0080_0000 | ($urandom & 32'hFF00_0000);
      2:       return $urandom & 32'hFF00_0000;
      3:       return $urandom;
      default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
    endcase
  endfunction

  // Mostly a measurement that tracks the setpoint, sometimes noise or a rail
  function automatic logic signed [POS_W-1:0] next_position();
    longint p;
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        p = m_setpoint + longint'($urandom_range(0, 1 << 19)) - (longint'(1) << 18);
        return POS_W'(sat_data(p));
      end
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  // One register transfer; the caller drops cfg_valid after the last of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TARGET: m_target = data;
      REG_RAMP:   m_ramp   = data[RAMP_W-1:0];
      REG_KP:     m_kp     = data[GAIN_W-1:0];
      REG_KI:     m_ki     = data[GAIN_W-1:0];
      REG_KD:     m_kd     = data[GAIN_W-1:0];
      default:    ;
    endcase
  endtask

  // Offer one sample, optionally after a gap, and queue its drive on transfer
  task automatic send_sample(input logic signed [POS_W-1:0] pos, input bit known,
                             input logic signed [DRIVE_W-1:0] want);
    logic signed [DRIVE_W-1:0] predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    measured_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = next_drive(pos);
    pending_drives.push_back(known ? want : predicted);
  endtask

  // Clock: 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop on a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Drive receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each drive transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: drive %0d with no sample outstanding", $time, drive);
        mismatches++;
      end else if (drive !== pending_drives[0]) begin
        $display("%0t: drive mismatch, expected %0d, actual %0d",
                 $time, pending_drives[0], drive);
        mismatches++;
        void'(pending_drives.pop_front());
      end else begin
        void'(pending_drives.pop_front());
      end
    end
  end

  // Stimulus
  initial begin
    logic [CFG_DATA_W-1:0] tgt;
    logic [CFG_DATA_W-1:0] rt;
    int                    sent;
    int                    phase;
    int                    len;

    rst               <= 1'b1;
    in_valid          <= 1'b0;
    measured_position <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    m_target   = TARGET_RST;
    m_ramp     = RAMP_RST;
    m_kp       = KP_RST;
    m_ki       = KI_RST;
    m_kd       = KD_RST;
    m_setpoint = 0;
    m_integral = 0;
    m_prev_err = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; config batches wait for the block to drain
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (i == 0 || directed_rows[i-1].kind != ROW_CFG) begin
          in_valid <= 1'b0;
          wait_idle();
        end
        write_reg(directed_rows[i].idx, directed_rows[i].value);
        if (directed_rows[i+1].kind != ROW_CFG) begin
          cfg_valid <= 1'b0;
        end
      end else begin
        send_sample(directed_rows[i].value, directed_rows[i].kind == ROW_SAMPLE_KNOWN,
                    directed_rows[i].want);
      end
    end

    // Random phases: drain, retune a random subset of registers, run a stretch of samples
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      in_valid <= 1'b0;
      wait_idle();

      case ($urandom_range(0, 9))
        0:       tgt = 32'h7FFF_FFFF;
        1:       tgt = 32'h8000_0000;
        2:       tgt = '0;
        3:       tgt = $urandom;
        default: tgt = 32'($urandom_range(0, 400 << 16)) - 32'(200 << 16);
      endcase
      case ($urandom_range(0, 9))
        0:       rt = '0;
        1:       rt = 32'd1;
        2:       rt = 32'hFFFF_FFFF;
        3:       rt = $urandom;
        default: rt = $urandom_range(6554, 4 << 16);
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(REG_TARGET, tgt);
      if ($urandom_range(0, 3) != 0) write_reg(REG_RAMP, rt);
      if ($urandom_range(0, 3) != 0) write_reg(REG_KP, pick_gain());
      if ($urandom_range(0, 3) != 0) write_reg(REG_KI, pick_gain());
      if ($urandom_range(0, 3) != 0) write_reg(REG_KD, pick_gain());
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
      end
      cfg_valid <= 1'b0;

      // Hold the receiver off while samples keep coming, so the input backs up
      if (phase == 2) begin
        hold_off_req = 1'b1;
      end

      len = $urandom_range(15, 60);
      for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
        quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
        send_sample(next_position(), 1'b0, '0);
        sent++;
      end
      phase++;
    end

    // Drain, then watch for stray drives
    in_valid <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
